/* design/nsc_pkg.sv */
// Package for the NAL start code splitter.
// Shared constants, result slot and queue word types. No dependencies.
package nsc_pkg;

  // Length counter width and the clamp applied at the output field
  localparam int LEN_BITS = 16;
  localparam int LEN_OUT_BITS = 16;

  // Result slots per queue word and queue depth
  localparam int NSLOTS = 4;
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);
  localparam int SLOT_BITS = $clog2(NSLOTS);

  // Start code bytes
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE = 8'h01;

  // End reason codes
  localparam logic REASON_CODE = 1'b0;
  localparam logic REASON_EOS = 1'b1;

  // Slot positions inside a queue word
  localparam int SLOT_HELD = 0;
  localparam int SLOT_ZERO0 = 1;
  localparam int SLOT_ZERO1 = 2;
  localparam int SLOT_TAIL = 3;

  // One pending result byte
  typedef struct packed {
    logic [7:0] nal_byte;
    logic       first;
    logic       last;
    logic       reason;
  } slot_t;

  // One queue word: the results caused by one input word
  typedef struct packed {
    logic [NSLOTS-1:0]        valid;
    slot_t [NSLOTS-1:0]       slot;
  } entry_t;

  // Front to queue write request
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  // Queue status toward front and back
  typedef struct packed {
    logic   full;
    logic   head_valid;
    entry_t head;
  } qstat_t;

endpackage

/* design/nsc_if.sv */
// Valid/ready channel interfaces for the splitter input and result streams.
// Depends on nothing.
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       end_of_stream;

  modport source (output valid, output stream_byte, output end_of_stream, input ready);
  modport sink (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface nsc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  nal_byte;
  logic        first_of_nal;
  logic        last_of_nal;
  logic [15:0] nal_length;
  logic        end_reason;

  modport source (output valid, output nal_byte, output first_of_nal, output last_of_nal,
                  output nal_length, output end_reason, input ready);
  modport sink (input valid, input nal_byte, input first_of_nal, input last_of_nal,
                input nal_length, input end_reason, output ready);
endinterface

/* design/nsc_front.sv */
// Front end: start code search and hold-back of zeros and the pending byte. Uses nsc_pkg.
// Turns each accepted word with results into one queue word of up to four result slots.
module nsc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      stream_byte,
  input  logic            end_of_stream,
  output nsc_pkg::push_t  push_o
);

  logic       in_unit_r, in_unit_nxt;
  logic [1:0] zero_run_r, zero_run_nxt;
  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic       held_first_r, held_first_nxt;

  nsc_pkg::entry_t ent;

  // Next state and result slots for the current word
  always_comb begin
    in_unit_nxt    = in_unit_r;
    zero_run_nxt   = zero_run_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    held_first_nxt = held_first_r;
    ent = '0;

    // Held byte never carries last here unless a start code or a zero run ends the unit
    ent.slot[nsc_pkg::SLOT_HELD].nal_byte = held_byte_r;
    ent.slot[nsc_pkg::SLOT_HELD].first    = held_first_r;
    ent.slot[nsc_pkg::SLOT_ZERO0].nal_byte = nsc_pkg::BYTE_ZERO;
    ent.slot[nsc_pkg::SLOT_ZERO0].first    = !held_valid_r;
    ent.slot[nsc_pkg::SLOT_ZERO1].nal_byte = nsc_pkg::BYTE_ZERO;
    ent.slot[nsc_pkg::SLOT_TAIL].nal_byte  = stream_byte;
    ent.slot[nsc_pkg::SLOT_TAIL].first     = !held_valid_r && (zero_run_r == 2'd0);

    if (!in_unit_r) begin
      // Search for two or more zeros followed by one
      if (end_of_stream) begin
        zero_run_nxt   = 2'd0;
        held_valid_nxt = 1'b0;
        held_first_nxt = 1'b0;
      end else if (stream_byte == nsc_pkg::BYTE_ZERO) begin
        if (zero_run_r != 2'd2) zero_run_nxt = zero_run_r + 2'd1;
      end else if (stream_byte == nsc_pkg::BYTE_ONE && zero_run_r == 2'd2) begin
        in_unit_nxt    = 1'b1;
        zero_run_nxt   = 2'd0;
        held_valid_nxt = 1'b0;
        held_first_nxt = 1'b0;
      end else begin
        zero_run_nxt = 2'd0;
      end
    end else if (end_of_stream) begin
      // Flush held byte, held zeros and this byte as the unit tail
      ent.valid[nsc_pkg::SLOT_HELD]  = held_valid_r;
      ent.valid[nsc_pkg::SLOT_ZERO0] = (zero_run_r != 2'd0);
      ent.valid[nsc_pkg::SLOT_ZERO1] = (zero_run_r == 2'd2);
      ent.valid[nsc_pkg::SLOT_TAIL]  = 1'b1;
      ent.slot[nsc_pkg::SLOT_TAIL].last   = 1'b1;
      ent.slot[nsc_pkg::SLOT_TAIL].reason = nsc_pkg::REASON_EOS;
      in_unit_nxt    = 1'b0;
      zero_run_nxt   = 2'd0;
      held_valid_nxt = 1'b0;
      held_first_nxt = 1'b0;
    end else if (zero_run_r == 2'd2 &&
                 (stream_byte == nsc_pkg::BYTE_ZERO || stream_byte == nsc_pkg::BYTE_ONE)) begin
      // Zero run or start code closes the unit on the held byte
      ent.valid[nsc_pkg::SLOT_HELD] = held_valid_r;
      ent.slot[nsc_pkg::SLOT_HELD].last   = 1'b1;
      ent.slot[nsc_pkg::SLOT_HELD].reason = nsc_pkg::REASON_CODE;
      held_valid_nxt = 1'b0;
      held_first_nxt = 1'b0;
      if (stream_byte == nsc_pkg::BYTE_ONE) begin
        in_unit_nxt  = 1'b1;
        zero_run_nxt = 2'd0;
      end else begin
        in_unit_nxt  = 1'b0;
        zero_run_nxt = 2'd2;
      end
    end else if (stream_byte == nsc_pkg::BYTE_ZERO) begin
      // Hold the zero back
      zero_run_nxt = zero_run_r + 2'd1;
    end else begin
      // Release held byte and zeros, hold this byte
      ent.valid[nsc_pkg::SLOT_HELD]  = held_valid_r;
      ent.valid[nsc_pkg::SLOT_ZERO0] = (zero_run_r != 2'd0);
      ent.valid[nsc_pkg::SLOT_ZERO1] = (zero_run_r == 2'd2);
      zero_run_nxt   = 2'd0;
      held_byte_nxt  = stream_byte;
      held_valid_nxt = 1'b1;
      held_first_nxt = !held_valid_r && (zero_run_r == 2'd0);
    end
  end

  assign push_o.push  = accept && (ent.valid != '0);
  assign push_o.entry = ent;

  // Advance search state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_unit_r    <= 1'b0;
      zero_run_r   <= 2'd0;
      held_valid_r <= 1'b0;
      held_first_r <= 1'b0;
    end else if (accept) begin
      in_unit_r    <= in_unit_nxt;
      zero_run_r   <= zero_run_nxt;
      held_valid_r <= held_valid_nxt;
      held_first_r <= held_first_nxt;
    end
  end

  // Hold the pending byte
  always_ff @(posedge clk) begin
    if (accept) held_byte_r <= held_byte_nxt;
  end

endmodule

/* design/nsc_queue.sv */
// Short queue of result words between the front end and the back end.
// Register file with read and write pointers. Uses nsc_pkg.
module nsc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  nsc_pkg::push_t   push_i,
  input  logic             pop,
  output nsc_pkg::qstat_t  stat_o
);

  nsc_pkg::entry_t mem_r [nsc_pkg::QDEPTH];
  logic [nsc_pkg::QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [nsc_pkg::QCNT_BITS-1:0] count_r;

  logic do_pop;

  assign do_pop            = pop && (count_r != '0);
  assign stat_o.full       = (count_r == nsc_pkg::QCNT_BITS'(nsc_pkg::QDEPTH));
  assign stat_o.head_valid = (count_r != '0);
  assign stat_o.head       = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i.push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push_i.push && !do_pop) count_r <= count_r + 1'b1;
      else if (!push_i.push && do_pop) count_r <= count_r - 1'b1;
    end
  end

  // Store pushed word
  always_ff @(posedge clk) begin
    if (push_i.push) mem_r[wr_ptr_r] <= push_i.entry;
  end

endmodule

/* design/nsc_back.sv */
// Back end: walks the slots of the head queue word, one result per cycle while the
// output is not stalled, counts unit length and drives the output register. Uses nsc_pkg.
module nsc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  nsc_pkg::qstat_t  stat_i,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       nal_byte,
  output logic             first_of_nal,
  output logic             last_of_nal,
  output logic [15:0]      nal_length,
  output logic             end_reason
);

  localparam logic [nsc_pkg::LEN_BITS-1:0] LEN_MAX = '1;

  logic [nsc_pkg::NSLOTS-1:0] done_r;
  logic [nsc_pkg::LEN_BITS-1:0] len_r, len_nxt;
  logic                         out_valid_r;
  logic [7:0]                   byte_r;
  logic                         first_r, last_r, reason_r;
  logic [nsc_pkg::LEN_OUT_BITS-1:0] length_r, length_nxt;

  logic [nsc_pkg::NSLOTS-1:0] pending, sel_oh, rest;
  logic [nsc_pkg::SLOT_BITS-1:0] sel;
  logic                          load;
  nsc_pkg::slot_t                cur;
  logic [31:0]                   len_wide;

  // Pick lowest pending slot of the head word
  always_comb begin
    pending = stat_i.head.valid & ~done_r;
    sel = '0;
    for (int i = nsc_pkg::NSLOTS - 1; i >= 0; i--) begin
      if (pending[i]) sel = nsc_pkg::SLOT_BITS'(i);
    end
    sel_oh = nsc_pkg::NSLOTS'(1) << sel;
    rest   = pending & ~sel_oh;
    cur    = stat_i.head.slot[sel];
  end

  assign load = stat_i.head_valid && (!out_valid_r || out_ready);
  assign pop  = load && (rest == '0);

  // Length count, restart on first byte, saturate, clamp for output
  always_comb begin
    if (cur.first) len_nxt = nsc_pkg::LEN_BITS'(1);
    else if (len_r == LEN_MAX) len_nxt = len_r;
    else len_nxt = len_r + 1'b1;
    len_wide = 32'(len_nxt);
    if (!cur.last) length_nxt = '0;
    else if (len_wide > 32'(16'hFFFF)) length_nxt = 16'hFFFF;
    else length_nxt = len_wide[nsc_pkg::LEN_OUT_BITS-1:0];
  end

  // Track consumed slots and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        done_r <= (rest == '0) ? '0 : (done_r | sel_oh);
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load output payload and length counter
  always_ff @(posedge clk) begin
    if (load) begin
      len_r    <= len_nxt;
      byte_r   <= cur.nal_byte;
      first_r  <= cur.first;
      last_r   <= cur.last;
      reason_r <= cur.last & cur.reason;
      length_r <= length_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign nal_byte     = byte_r;
  assign first_of_nal = first_r;
  assign last_of_nal  = last_r;
  assign nal_length   = length_r;
  assign end_reason   = reason_r;

endmodule

/* design/nal_start_code_splitter_top.sv */
// Top level of the H.264 Annex B start code splitter.
// Instantiates nsc_front, nsc_queue and nsc_back; uses nsc_pkg and nsc_if.
//
//   channel  dir  payload                                           handshake
//   in_ch    in   stream_byte[8], end_of_stream                     valid/ready
//   out_ch   out  nal_byte[8], first_of_nal, last_of_nal,           valid/ready
//                 nal_length[16], end_reason
//
// One input word per cycle while the four-word queue has room; in_ch.ready is
// simply "queue not full". A word yields 0 to 4 result words; the back end
// sends one result word per cycle while out_ch is not stalled, so a word with
// k results holds its queue slot until all k are loaded; output is registered.
// Synchronous active-low reset clears search state, queue and output valid.
// A stall on out_ch fills the queue and then drops in_ch.ready.
module nal_start_code_splitter_top (
  input  logic        clk,
  input  logic        rst_n,
  nsc_in_if.sink      in_ch,
  nsc_out_if.source   out_ch
);

  nsc_pkg::push_t  push;
  nsc_pkg::qstat_t qstat;
  logic            accept;
  logic            pop;

  assign in_ch.ready = !qstat.full;
  assign accept      = in_ch.valid && !qstat.full;

  nsc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .stream_byte   (in_ch.stream_byte),
    .end_of_stream (in_ch.end_of_stream),
    .push_o        (push)
  );

  nsc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .stat_o (qstat)
  );

  nsc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .stat_i       (qstat),
    .pop          (pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .nal_byte     (out_ch.nal_byte),
    .first_of_nal (out_ch.first_of_nal),
    .last_of_nal  (out_ch.last_of_nal),
    .nal_length   (out_ch.nal_length),
    .end_reason   (out_ch.end_reason)
  );

endmodule

/* design/nsc_checker.sv */
// Port-level checks for the start code splitter result stream.
// Bound to nal_start_code_splitter_top; no package dependency.
module nsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  nal_byte,
  input logic        first_of_nal,
  input logic        last_of_nal,
  input logic [15:0] nal_length,
  input logic        end_reason
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(nal_byte) && $stable(nal_length))
    else $error("result word changed while stalled");

  // Length appears only on the last byte
  a_len_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last_of_nal |-> nal_length == 16'd0)
    else $error("length on non-last byte");

  // A one-byte unit reports length one
  a_len_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_of_nal && last_of_nal |-> nal_length == 16'd1)
    else $error("single-byte unit with wrong length");

  // End reason is set only on the last byte, with a nonzero length
  a_reason_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_reason |-> last_of_nal && nal_length != 16'd0)
    else $error("end reason without last byte");

endmodule

bind nal_start_code_splitter_top nsc_checker u_nsc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .nal_byte     (out_ch.nal_byte),
  .first_of_nal (out_ch.first_of_nal),
  .last_of_nal  (out_ch.last_of_nal),
  .nal_length   (out_ch.nal_length),
  .end_reason   (out_ch.end_reason)
);
